[design/bcs_pkg.sv]
// Shared constants for the Bezier curve sampler.
package bcs_pkg;
    localparam int MAX_POINTS = 32;
    localparam int PT_AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int PT_W       = 3 * COORD_W;
    localparam int Q_W        = 31;
    localparam int FRAC_W     = 30;
    localparam int BIN_W      = 30;
    localparam int DVD_W      = 36;
    localparam int DVS_W      = 7;
    localparam int OC_W       = 7;
    localparam int IDX_W      = 6;
    localparam logic [Q_W-1:0]  ONE_Q30      = Q_W'(1) << FRAC_W;
    localparam logic [OC_W-1:0] OC_RESET     = OC_W'(16);
    localparam logic [OC_W-1:0] OC_MIN       = OC_W'(2);
    localparam logic [OC_W-1:0] OC_MAX       = OC_W'(64);
endpackage

[design/bcs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module bcs_ram #(
    parameter int W  = 32,
    parameter int D  = 32,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/bcs_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
module bcs_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bcs_pkg::DVD_W-1:0] i_dividend,
    input  logic [bcs_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [bcs_pkg::DVD_W-1:0] o_quot
);
    import bcs_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_d;
    logic              r_done;
    logic [DVS_W:0]    w_shift;
    logic [DVS_W:0]    w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_q[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};
    assign w_ge    = (w_shift >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[design/bezier_curve_sampler.sv]
// Each sample is computed by a sequencer that stalls on output back-pressure; the serial
// divider (one bit a cycle) forms t and each binomial.
// Throughput: one control point per cycle while idle; input stalls during emission.
// Reset (synchronous, active low) clears point count, dropped flag, output valid,
// and sets out_count to 16; the point store is not cleared.
module bezier_curve_sampler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [bcs_pkg::OC_W-1:0]    i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [31:0]          i_ctrl_x,
    input  logic signed [31:0]          i_ctrl_y,
    input  logic signed [31:0]          i_ctrl_z,
    input  logic                        i_last_point,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_out_x,
    output logic signed [31:0]          o_out_y,
    output logic signed [31:0]          o_out_z,
    output logic [5:0]                  o_sample_index,
    output logic                        o_last_sample,
    output logic                        o_overflow
);
    import bcs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TDIV  = 4'd1;
    localparam logic [3:0] S_TWAIT = 4'd2;
    localparam logic [3:0] S_UPOW  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_Q     = 4'd5;
    localparam logic [3:0] S_B     = 4'd6;
    localparam logic [3:0] S_TERM  = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_CDIV  = 4'd9;
    localparam logic [3:0] S_CWAIT = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]             r_state;
    logic [OC_W-1:0]        r_oc;
    logic [CNT_W-1:0]       r_pcount;
    logic                   r_drop;
    logic [PT_AW-1:0]       r_n;
    logic [OC_W-1:0]        r_cnt;
    logic                   r_ovf;
    logic [OC_W-1:0]        r_k;
    logic [PT_AW-1:0]       r_i;
    logic [PT_AW-1:0]       r_j;
    logic [Q_W-1:0]         r_t;
    logic [Q_W-1:0]         r_u;
    logic [Q_W-1:0]         r_pw;
    logic [Q_W-1:0]         r_tp;
    logic [Q_W-1:0]         r_q;
    logic [Q_W-1:0]         r_b;
    logic [BIN_W-1:0]       r_c;
    logic [DVD_W-1:0]       r_dvd;
    logic signed [31:0]     r_tx, r_ty, r_tz;
    logic signed [31:0]     r_ax, r_ay, r_az;

    logic                   r_ov;
    logic signed [31:0]     r_ox, r_oy, r_oz;
    logic [IDX_W-1:0]       r_oidx;
    logic                   r_olast;
    logic                   r_oovf;

    logic                   w_in_acc;
    logic                   w_full;
    logic                   w_pt_we;
    logic [PT_W-1:0]        w_pt_rd;
    logic [Q_W-1:0]         w_up_rd;
    logic                   w_rd;
    logic                   w_div_start;
    logic [DVD_W-1:0]       w_div_dvd;
    logic [DVS_W-1:0]       w_div_dvs;
    logic                   w_div_done;
    logic [DVD_W-1:0]       w_div_q;
    logic                   w_load;
    logic [CNT_W-1:0]       w_npts;
    logic [OC_W-1:0]        w_cnt_cl;
    logic [2*Q_W-1:0]       w_mq;
    logic [2*Q_W-1:0]       w_mt;
    logic [2*Q_W-1:0]       w_mpw;
    logic [Q_W+BIN_W-1:0]   w_mb;
    logic signed [63:0]     w_px, w_py, w_pz;

    assign w_in_acc = i_valid && !o_stall;
    assign w_full   = (r_pcount == CNT_W'(MAX_POINTS));
    assign w_pt_we  = w_in_acc && !w_full;
    assign w_npts   = w_full ? r_pcount : r_pcount + 1'b1;
    assign w_cnt_cl = (r_oc < OC_MIN) ? OC_MIN : ((r_oc > OC_MAX) ? OC_MAX : r_oc);
    assign w_rd     = (r_state == S_RD);
    assign w_load   = (r_state == S_OUT) && (!r_ov || !i_stall);

    bcs_ram #(.W(PT_W), .D(MAX_POINTS)) u_pts (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_pcount[PT_AW-1:0]),
        .i_wdata ({i_ctrl_x, i_ctrl_y, i_ctrl_z}),
        .i_re    (w_rd),
        .i_raddr (r_i),
        .o_rdata (w_pt_rd)
    );

    bcs_ram #(.W(Q_W), .D(MAX_POINTS)) u_upow (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPOW),
        .i_waddr (r_j),
        .i_wdata (r_pw),
        .i_re    (w_rd),
        .i_raddr (r_n - r_i),
        .o_rdata (w_up_rd)
    );

    assign w_div_start = (r_state == S_TDIV) || (r_state == S_CDIV);
    assign w_div_dvd   = (r_state == S_TDIV) ? {r_k[IDX_W-1:0], {FRAC_W{1'b0}}} : r_dvd;
    assign w_div_dvs   = (r_state == S_TDIV) ? DVS_W'(r_cnt - 1'b1)
                                             : DVS_W'({1'b0, r_i} + 1'b1);

    bcs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    assign w_mq  = r_tp * w_up_rd;
    assign w_mt  = r_tp * r_t;
    assign w_mpw = r_pw * r_u;
    assign w_mb  = r_q * r_c;
    assign w_px  = $signed(w_pt_rd[3*COORD_W-1:2*COORD_W]) * $signed({1'b0, r_b});
    assign w_py  = $signed(w_pt_rd[2*COORD_W-1:COORD_W]) * $signed({1'b0, r_b});
    assign w_pz  = $signed(w_pt_rd[COORD_W-1:0]) * $signed({1'b0, r_b});

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oc     <= OC_RESET;
            r_pcount <= '0;
            r_drop   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_oc <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_last_point) begin
                            r_pcount <= '0;
                            r_drop   <= 1'b0;
                            if (w_npts >= CNT_W'(2)) begin
                                r_state <= S_TDIV;
                            end
                        end else if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_pcount <= r_pcount + 1'b1;
                        end
                    end
                end
                S_TDIV:  r_state <= S_TWAIT;
                S_TWAIT: if (w_div_done) r_state <= S_UPOW;
                S_UPOW:  if (r_j == r_n) r_state <= S_RD;
                S_RD:    r_state <= S_Q;
                S_Q:     r_state <= S_B;
                S_B:     r_state <= S_TERM;
                S_TERM:  r_state <= S_ACC;
                S_ACC:   r_state <= (r_i == r_n) ? S_OUT : S_CDIV;
                S_CDIV:  r_state <= S_CWAIT;
                S_CWAIT: if (w_div_done) r_state <= S_RD;
                S_OUT: begin
                    if (w_load) begin
                        r_state <= (r_k == r_cnt - 1'b1) ? S_IDLE : S_TDIV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_last_point) begin
                    r_n   <= PT_AW'(w_npts - 1'b1);
                    r_cnt <= w_cnt_cl;
                    r_ovf <= r_drop || w_full;
                    r_k   <= '0;
                end
            end
            S_TWAIT: begin
                r_t  <= w_div_q[Q_W-1:0];
                r_u  <= ONE_Q30 - w_div_q[Q_W-1:0];
                r_pw <= ONE_Q30;
                r_j  <= '0;
                r_tp <= ONE_Q30;
                r_c  <= BIN_W'(1);
                r_i  <= '0;
                r_ax <= '0;
                r_ay <= '0;
                r_az <= '0;
            end
            S_UPOW: begin
                r_pw <= w_mpw[FRAC_W+Q_W-1:FRAC_W];
                r_j  <= r_j + 1'b1;
            end
            S_Q: r_q <= w_mq[FRAC_W+Q_W-1:FRAC_W];
            S_B: begin
                r_b  <= (w_mb > (Q_W+BIN_W)'(ONE_Q30)) ? ONE_Q30 : w_mb[Q_W-1:0];
                r_tp <= w_mt[FRAC_W+Q_W-1:FRAC_W];
            end
            S_TERM: begin
                r_tx <= w_px[61:30];
                r_ty <= w_py[61:30];
                r_tz <= w_pz[61:30];
            end
            S_ACC: begin
                r_ax  <= sat_add(r_ax, r_tx);
                r_ay  <= sat_add(r_ay, r_ty);
                r_az  <= sat_add(r_az, r_tz);
                r_dvd <= DVD_W'(r_c) * DVD_W'(r_n - r_i);
            end
            S_CWAIT: begin
                if (w_div_done) begin
                    r_c <= w_div_q[BIN_W-1:0];
                    r_i <= r_i + 1'b1;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ox    <= r_ax;
            r_oy    <= r_ay;
            r_oz    <= r_az;
            r_oidx  <= r_k[IDX_W-1:0];
            r_olast <= (r_k == r_cnt - 1'b1);
            r_oovf  <= r_ovf;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ov;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_z        = r_oz;
    assign o_sample_index = r_oidx;
    assign o_last_sample  = r_olast;
    assign o_overflow     = r_oovf;

`ifndef SYNTHESIS
    a_pcount_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov)
        else $error("pending transaction lost");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_TWAIT || r_state == S_CWAIT))
        else $error("divider finished outside a wait state");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && o_last_sample == 1'b0 && r_k == r_cnt - 1'b1 |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle");
`endif
endmodule

[verif/bezier_curve_sampler_test.sv]
// Self-checking testbench for the Bezier curve sampler: directed table plus random curves.
`timescale 1ns / 1ps

module bezier_curve_sampler_test;
    import bcs_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         idx;
        logic               last;
        logic               ovf;
    } t_sample;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
        logic               chk;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [OC_W-1:0]    i_cfg_wr_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_ctrl_x = '0;
    logic signed [31:0] i_ctrl_y = '0;
    logic signed [31:0] i_ctrl_z = '0;
    logic               i_last_point = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic [5:0]         o_sample_index;
    logic               o_last_sample;
    logic               o_overflow;

    bezier_curve_sampler dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] pts_x [MAX_POINTS];
    logic signed [31:0] pts_y [MAX_POINTS];
    logic signed [31:0] pts_z [MAX_POINTS];
    int                 held_points;
    bit                 dropped;
    int                 sample_cfg = 16;
    t_sample            expected_samples [$];
    t_row               directed_rows [$];
    int                 errors;
    int                 samples_seen;
    int                 curves_done;
    bit                 rx_noidle;
    bit                 rx_hold;

    function automatic longint q30_mul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint q30_pow(longint b, int e);
        longint r = 64'd1 << 30;
        for (int j = 0; j < e; j++) r = q30_mul(r, b);
        return r;
    endfunction

    function automatic longint choose(int n, int i);
        longint c = 1;
        for (int j = 0; j < i; j++) c = c * (n - j) / (j + 1);
        return c;
    endfunction

    function automatic longint weighted(longint p, longint b);
        longint m = (p < 0) ? -p : p;
        longint pr = m * b;
        if (p >= 0) return pr >>> 30;
        return -((pr + (64'd1 << 30) - 1) >>> 30);
    endfunction

    function automatic longint clamp_add(longint a, longint v);
        longint s = a + v;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    // returns number of samples queued
    function automatic int absorb_point(logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z, logic lp);
        int np, n, cnt;
        bit ov;
        longint t, u, b, ax, ay, az;
        t_sample s;
        if (held_points < MAX_POINTS) begin
            pts_x[held_points] = x;
            pts_y[held_points] = y;
            pts_z[held_points] = z;
            held_points++;
        end else begin
            dropped = 1'b1;
        end
        if (!lp) return 0;
        np = held_points;
        ov = dropped;
        held_points = 0;
        dropped = 1'b0;
        curves_done++;
        if (np < 2) return 0;
        n = np - 1;
        cnt = sample_cfg < 2 ? 2 : (sample_cfg > 64 ? 64 : sample_cfg);
        for (int k = 0; k < cnt; k++) begin
            t = (longint'(k) << 30) / (cnt - 1);
            u = (64'd1 << 30) - t;
            ax = 0; ay = 0; az = 0;
            for (int i = 0; i <= n; i++) begin
                b = q30_mul(q30_pow(t, i), q30_pow(u, n - i)) * choose(n, i);
                if (b > (64'd1 << 30)) b = 64'd1 << 30;
                ax = clamp_add(ax, weighted(pts_x[i], b));
                ay = clamp_add(ay, weighted(pts_y[i], b));
                az = clamp_add(az, weighted(pts_z[i], b));
            end
            s.x = ax[31:0]; s.y = ay[31:0]; s.z = az[31:0];
            s.idx = k[5:0];
            s.last = (k == cnt - 1);
            s.ovf = ov;
            expected_samples.insert(expected_samples.size(), s);
        end
        return cnt;
    endfunction

    // receiver: random stall, optional long hold
    always @(negedge i_clk) begin
        if (rx_hold) i_stall <= 1'b1;
        else if (rx_noidle) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 27);
    end

    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && o_valid && !i_stall) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                $display("%0t unexpected sample x=%0d y=%0d z=%0d idx=%0d",
                         $time, o_out_x, o_out_y, o_out_z, o_sample_index);
                errors++;
            end else begin
                e = expected_samples.pop_front();
                if (o_out_x !== e.x || o_out_y !== e.y || o_out_z !== e.z ||
                    o_sample_index !== e.idx || o_last_sample !== e.last ||
                    o_overflow !== e.ovf) begin
                    $display("%0t mismatch exp x=%0d y=%0d z=%0d idx=%0d last=%0b ovf=%0b",
                             $time, e.x, e.y, e.z, e.idx, e.last, e.ovf);
                    $display("%0t          act x=%0d y=%0d z=%0d idx=%0d last=%0b ovf=%0b",
                             $time, o_out_x, o_out_y, o_out_z, o_sample_index,
                             o_last_sample, o_overflow);
                    errors++;
                end
            end
        end
    end

    // valid stays up between back-to-back transactions; drain drops it
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic lp, bit gaps);
        int dummy;
        while (gaps && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ctrl_x <= x; i_ctrl_y <= y; i_ctrl_z <= z; i_last_point <= lp;
        do @(posedge i_clk); while (o_stall);
        dummy = absorb_point(x, y, z, lp);
        @(negedge i_clk);
    endtask

    task automatic drain;
        int guard = 0;
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        while (guard < 3000) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    task automatic write_count(logic [OC_W-1:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sample_cfg = v;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_curve(int len, bit gaps);
        for (int j = 0; j < len; j++)
            send_point(rand_coord(), rand_coord(), rand_coord(), j == len - 1, gaps);
    endtask

    function automatic void add_row(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic lp, logic chk = 0,
                                    logic signed [31:0] ex = 0,
                                    logic signed [31:0] ey = 0,
                                    logic signed [31:0] ez = 0);
        t_row r;
        r.x = x; r.y = y; r.z = z; r.last = lp;
        r.chk = chk; r.ex = ex; r.ey = ey; r.ez = ez;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    initial begin
        int sent;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single point: no samples
        add_row(32'sd65536, 32'sd0, 32'sd0, 1'b1);
        // constant curve on exactly scaled coordinates: every sample equals the point
        add_row(32'sh80000000, 32'sh40000000, 32'sd0, 1'b0);
        add_row(32'sh80000000, 32'sh40000000, 32'sd0, 1'b1, 1'b1,
                32'sh80000000, 32'sh40000000, 32'sd0);
        add_row(32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 1'b0);
        add_row(32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 1'b1);
        add_row(32'sd0, -32'sd65536, 32'sd123456, 1'b0);
        add_row(32'sd65536, 32'sd65536, -32'sd123456, 1'b0);
        add_row(-32'sd65536, 32'sd327680, 32'sd7, 1'b1);
        foreach (directed_rows[j]) begin
            int base = expected_samples.size();
            send_point(directed_rows[j].x, directed_rows[j].y, directed_rows[j].z,
                       directed_rows[j].last, 1'b0);
            if (directed_rows[j].chk)
                for (int q = base; q < expected_samples.size(); q++)
                    if (expected_samples[q].x !== directed_rows[j].ex ||
                        expected_samples[q].y !== directed_rows[j].ey ||
                        expected_samples[q].z !== directed_rows[j].ez) begin
                        $display("%0t table mismatch exp x=%0d act x=%0d", $time,
                                 directed_rows[j].ex, expected_samples[q].x);
                        errors++;
                    end
        end

        // out of range and extreme counts
        write_count(7'd0);
        send_curve(2, 1'b0);
        write_count(7'd127);
        send_curve(3, 1'b0);
        write_count(7'd2);
        send_curve(MAX_POINTS + 3, 1'b0);   // store full, drops flagged
        send_curve(MAX_POINTS, 1'b0);
        write_count(7'd64);
        send_curve(2, 1'b0);
        write_count(7'd1);
        send_curve(4, 1'b0);

        // receiver holds off while sender keeps offering
        write_count(7'd8);
        rx_hold = 1'b1;
        fork
            begin
                int hold_cnt = 0;
                while (hold_cnt < 400) begin
                    @(negedge i_clk);
                    hold_cnt++;
                end
                rx_hold = 1'b0;
            end
        join_none
        send_curve(3, 1'b0);
        send_curve(2, 1'b0);
        wait fork;
        drain();

        sent = 0;
        while (sent < 170) begin
            int len;
            if (sent % 60 == 0)
                write_count(($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                      : 7'($urandom_range(2, 12)));
            rx_noidle = (sent >= 120 && sent < 150);
            case ($urandom_range(9))
                0: len = 1;
                1: len = $urandom_range(20, MAX_POINTS + 2);
                default: len = $urandom_range(2, 5);
            endcase
            send_curve(len, !rx_noidle);
            sent += len;
            if ($urandom_range(7) == 0) drain();
        end
        drain();
        $display("ran %0d curves, checked %0d samples incl. count extremes and store overflow",
                 curves_done, samples_seen);
        if (errors == 0 && expected_samples.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end
endmodule

[files.f]
design/bcs_pkg.sv
design/bcs_ram.sv
design/bcs_divider.sv
design/bezier_curve_sampler.sv
verif/bezier_curve_sampler_test.sv
